// ===== hw/rtl/hrlf_pkg.sv =====
`timescale 1ns / 1ps

package hrlf_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 32;

   // "Content-Length:" and the slot count of the per-position match vector
   localparam int PAT_LEN   = 15;
   localparam int PAT_SLOTS = 16;

   localparam logic [7:0] PATTERN [PAT_LEN] = '{
      8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
      8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a
   };

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // phase codes as seen on the result channel
   localparam logic [1:0] PHASE_SEARCH = 2'd0;
   localparam logic [1:0] PHASE_HEADER = 2'd1;
   localparam logic [1:0] PHASE_BODY   = 2'd2;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_SEARCH = 3'b001,
      ST_HEADER = 3'b010,
      ST_BODY   = 3'b100
   } phase_type;

   // what the front end learns about one byte
   typedef struct packed {
      logic [PAT_SLOTS-1:0] pat_hit;
      logic                 is_digit;
      logic [3:0]           digit;
      logic                 is_space;
      logic                 is_cr;
      logic                 is_lf;
   } class_type;

endpackage

// ===== hw/rtl/hrlf_front.sv =====
`timescale 1ns / 1ps

module hrlf_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  queue_full,
   output logic                  push,
   output hrlf_pkg::class_type   push_class
);

   logic [3:0] digit_raw;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;
   assign digit_raw = req_data_byte[3:0] - hrlf_pkg::CHAR_ZERO[3:0];

   always_comb begin
      push_class = '0;
      for (int i = 0; i < hrlf_pkg::PAT_LEN; i++) begin
         push_class.pat_hit[i] = (req_data_byte == hrlf_pkg::PATTERN[i]);
      end
      push_class.is_digit = (req_data_byte >= hrlf_pkg::CHAR_ZERO) &&
                            (req_data_byte <= hrlf_pkg::CHAR_NINE);
      push_class.digit    = digit_raw;
      push_class.is_space = (req_data_byte == hrlf_pkg::CHAR_SPACE);
      push_class.is_cr    = (req_data_byte == hrlf_pkg::CHAR_CR);
      push_class.is_lf    = (req_data_byte == hrlf_pkg::CHAR_LF);
   end

endmodule

// ===== hw/rtl/hrlf_queue.sv =====
`timescale 1ns / 1ps

module hrlf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hrlf_pkg::class_type   push_class,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output hrlf_pkg::class_type   head_class
);

   localparam int PW = hrlf_pkg::QPTR_WIDTH;
   localparam int CW = hrlf_pkg::QCOUNT_WIDTH;

   hrlf_pkg::class_type entries_ff [hrlf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(hrlf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_class = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(hrlf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(hrlf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule

// ===== hw/rtl/hrlf_back.sv =====
`timescale 1ns / 1ps

module hrlf_back #(
   parameter int COUNT_WIDTH = hrlf_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  hrlf_pkg::class_type   head_class,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_response_done,
   output logic [1:0]            rsp_phase
);

   localparam int WW = COUNT_WIDTH + 4;

   hrlf_pkg::phase_type phase_ff, phase_in;
   logic [3:0]             match_ff, match_in;
   logic                   in_value_ff, in_value_in;
   logic [COUNT_WIDTH-1:0] length_ff, length_in;
   logic [COUNT_WIDTH-1:0] body_ff, body_in;
   logic [1:0]             crlf_ff, crlf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_done_ff, done_in;
   logic [1:0]             rsp_phase_ff, phase_code;

   logic [WW-1:0]          length_x10;
   logic [COUNT_WIDTH-1:0] body_inc;
   logic                   crlf_hit;
   logic                   pat_hit;
   logic [3:0]             match_inc;

   assign pop               = head_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_response_done = rsp_done_ff;
   assign rsp_phase         = rsp_phase_ff;

   // length * 10 + digit, wide enough to see overflow
   assign length_x10 = {1'b0, length_ff, 3'b000} + {3'b000, length_ff, 1'b0} +
                       WW'(head_class.digit);
   assign body_inc   = body_ff + 1'b1;
   assign match_inc  = match_ff + 1'b1;
   assign pat_hit    = (match_ff < 4'(hrlf_pkg::PAT_LEN)) && head_class.pat_hit[match_ff];

   always_comb begin
      phase_in    = phase_ff;
      match_in    = match_ff;
      in_value_in = in_value_ff;
      length_in   = length_ff;
      body_in     = body_ff;
      crlf_in     = crlf_ff;
      done_in     = 1'b0;
      crlf_hit    = 1'b0;

      unique case (phase_ff)
         hrlf_pkg::ST_HEADER: begin
            crlf_hit = crlf_ff[0] ? head_class.is_lf : head_class.is_cr;
            if (crlf_hit) begin
               if (crlf_ff == 2'd3) begin
                  crlf_in = 2'd0;
                  body_in = '0;
                  if (length_ff == '0) begin
                     phase_in = hrlf_pkg::ST_SEARCH;
                     match_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     phase_in = hrlf_pkg::ST_BODY;
                  end
               end else begin
                  crlf_in = crlf_ff + 1'b1;
               end
            end else begin
               crlf_in = head_class.is_cr ? 2'd1 : 2'd0;
            end
         end
         hrlf_pkg::ST_BODY: begin
            body_in = body_inc;
            if (body_inc == length_ff) begin
               phase_in = hrlf_pkg::ST_SEARCH;
               match_in = '0;
               crlf_in  = 2'd0;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = hrlf_pkg::ST_SEARCH;
            if (in_value_ff) begin
               if (head_class.is_digit) begin
                  length_in = (length_x10[WW-1:COUNT_WIDTH] != '0) ? '1 :
                              length_x10[COUNT_WIDTH-1:0];
                  match_in  = 4'd1;
               end else if (head_class.is_space && match_ff == '0) begin
                  // leading space
               end else begin
                  // terminator is also the first byte of the header end search
                  in_value_in = 1'b0;
                  match_in    = '0;
                  if (head_class.is_cr) begin
                     crlf_in = 2'd1;
                  end else begin
                     crlf_in = 2'd0;
                  end
                  phase_in = hrlf_pkg::ST_HEADER;
               end
            end else begin
               if (pat_hit) begin
                  if (match_inc == 4'(hrlf_pkg::PAT_LEN)) begin
                     in_value_in = 1'b1;
                     match_in    = '0;
                     length_in   = '0;
                  end else begin
                     match_in = match_inc;
                  end
               end else begin
                  match_in = head_class.pat_hit[0] ? 4'd1 : 4'd0;
               end
            end
         end
      endcase

      unique case (phase_in)
         hrlf_pkg::ST_HEADER: phase_code = hrlf_pkg::PHASE_HEADER;
         hrlf_pkg::ST_BODY:   phase_code = hrlf_pkg::PHASE_BODY;
         default:             phase_code = hrlf_pkg::PHASE_SEARCH;
      endcase

      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hrlf_pkg::ST_SEARCH;
         match_ff     <= '0;
         in_value_ff  <= 1'b0;
         length_ff    <= '0;
         body_ff      <= '0;
         crlf_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            match_ff    <= match_in;
            in_value_ff <= in_value_in;
            length_ff   <= length_in;
            body_ff     <= body_in;
            crlf_ff     <= crlf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_done_ff  <= done_in;
         rsp_phase_ff <= phase_code;
      end
   end

endmodule

// ===== hw/rtl/http_response_length_framer.sv =====
`timescale 1ns / 1ps

// Streaming HTTP response framer: one byte of the response stream per beat in,
// one result beat out for every byte, carrying response_done (this byte ends a
// response: the last body byte, or the final LF of the header when the length
// is zero) and the phase after the byte (0 length search, 1 header end search,
// 2 body). The Content-Length value saturates at 2^COUNT_WIDTH - 1. Matching
// carries across any segment boundaries. A byte is classified in the front
// end, waits in a two-entry queue, and is parsed by the back end state
// machine, which updates on each byte it pops; sustained rate is one byte per
// clock while rsp_stall is low. An accepted byte is registered in a queue entry and
// its result beat in an output register, held there while rsp_stall is high.
module http_response_length_framer #(
   parameter int COUNT_WIDTH = hrlf_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_response_done,
   output logic [1:0] rsp_phase
);

   logic                queue_full;
   logic                push;
   hrlf_pkg::class_type push_class;
   logic                pop;
   logic                head_valid;
   hrlf_pkg::class_type head_class;

   hrlf_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_class    (push_class)
   );

   hrlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_class (push_class),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_class (head_class)
   );

   hrlf_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_class        (head_class),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_response_done (rsp_response_done),
      .rsp_phase         (rsp_phase)
   );

endmodule
